>>> rtl/tsm_pkg.sv
`default_nettype none
package tsm_pkg;

    localparam int unsigned IP_W = 10;

    localparam logic [4:0] OP_PUSH  = 5'd0;
    localparam logic [4:0] OP_POP   = 5'd1;
    localparam logic [4:0] OP_DUP   = 5'd2;
    localparam logic [4:0] OP_ADD   = 5'd3;
    localparam logic [4:0] OP_SUB   = 5'd4;
    localparam logic [4:0] OP_MUL   = 5'd5;
    localparam logic [4:0] OP_DIV   = 5'd6;
    localparam logic [4:0] OP_JMP   = 5'd7;
    localparam logic [4:0] OP_JIT   = 5'd8;
    localparam logic [4:0] OP_JIF   = 5'd9;
    localparam logic [4:0] OP_CALL  = 5'd10;
    localparam logic [4:0] OP_RET   = 5'd11;
    localparam logic [4:0] OP_STS   = 5'd12;
    localparam logic [4:0] OP_RCS   = 5'd13;
    localparam logic [4:0] OP_EQ    = 5'd14;
    localparam logic [4:0] OP_GT    = 5'd15;
    localparam logic [4:0] OP_GE    = 5'd16;
    localparam logic [4:0] OP_LT    = 5'd17;
    localparam logic [4:0] OP_LE    = 5'd18;
    localparam logic [4:0] OP_NE    = 5'd19;
    localparam logic [4:0] OP_STO   = 5'd20;
    localparam logic [4:0] OP_RCL   = 5'd21;
    localparam logic [4:0] OP_END   = 5'd22;
    localparam logic [4:0] OP_PRN   = 5'd23;
    localparam logic [4:0] OP_ATR   = 5'd24;
    localparam logic [4:0] OP_ENTRY = 5'd25;
    localparam logic [4:0] OP_LEAVE = 5'd26;
    localparam logic [4:0] OP_MOV   = 5'd27;
    localparam logic [4:0] OP_ATK   = 5'd28;
    localparam logic [4:0] OP_INF   = 5'd29;
    localparam logic [4:0] OP_CLT   = 5'd30;
    localparam logic [4:0] OP_DEP   = 5'd31;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_TYPE  = 3'd1;
    localparam logic [2:0] ERR_DIV0  = 3'd2;
    localparam logic [2:0] ERR_STACK = 3'd3;
    localparam logic [2:0] ERR_FRAME = 3'd4;

    localparam logic [1:0] TAG_NUM = 2'd0;

    typedef struct packed {
        logic [4:0]         func;
        logic signed [31:0] arg_value;
        logic [1:0]         arg_tag;
    } t_in_word;

    typedef struct packed {
        logic [IP_W-1:0]    next_ip;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic [1:0]         print_tag;
        logic               halted;
        logic [2:0]         error_code;
    } t_out_word;

    typedef struct packed {
        logic [1:0]  tag;
        logic [31:0] value;
    } t_word;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

>>> rtl/typed_stack_machine_step.sv
// Executes one stack-machine instruction per input word and returns one result word
// (next fetch address, print output, halt flag, error code). The data stack, return
// stack, frame bases and data memory sit in synchronous RAMs with registered reads, so an
// instruction passes through accept, operand read, execute and result hand-off before the
// next is accepted; a stalled output holds it in hand-off. DIV runs a radix-2 divider in
// an extra state. MEM_WORDS must be a power of two; data memory addresses wrap at it.
`default_nettype none
module typed_stack_machine_step
    import tsm_pkg::*;
#(
    parameter int unsigned STACK_DEPTH  = 64,
    parameter int unsigned RETURN_DEPTH = 16,
    parameter int unsigned FRAME_DEPTH  = 32,
    parameter int unsigned MEM_WORDS    = 256
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    localparam int unsigned DTW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned DAW = $clog2(STACK_DEPTH);
    localparam int unsigned RTW = $clog2(RETURN_DEPTH + 1);
    localparam int unsigned RAW = $clog2(RETURN_DEPTH);
    localparam int unsigned FAW = $clog2(FRAME_DEPTH);
    localparam int unsigned MAW = $clog2(MEM_WORDS);

    localparam logic [DTW-1:0] DS_FULL = DTW'(STACK_DEPTH);
    localparam logic [RTW-1:0] RS_FULL = RTW'(RETURN_DEPTH);
    localparam logic [FAW-1:0] FR_LAST = FAW'(FRAME_DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD2  = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]      r_state, n_state;
    t_in_word        r_in, n_in;
    t_word           r_a, n_a;
    logic [IP_W-1:0] r_ip, n_ip;
    logic [DTW-1:0]  r_dtop, n_dtop;
    logic [RTW-1:0]  r_rtop, n_rtop;
    logic [FAW-1:0]  r_fidx, n_fidx;
    t_out_word       r_res, n_res;
    logic            r_out_valid;
    t_out_word       r_out;

    // memories
    t_word          ds_mem [STACK_DEPTH];
    t_word          ds_q;
    logic [DAW-1:0] ds_raddr;
    logic           ds_we;
    logic [DAW-1:0] ds_waddr;
    t_word          ds_wdata;

    logic [IP_W-1:0] rs_mem [RETURN_DEPTH];
    logic [IP_W-1:0] rs_q;
    logic [RAW-1:0]  rs_raddr;
    logic            rs_we;

    logic [7:0]     fb_mem [FRAME_DEPTH];
    logic [7:0]     fb_q;
    logic           fb_we;
    logic [FAW-1:0] fb_waddr;
    logic [7:0]     fb_wdata;

    t_word          dm_mem [MEM_WORDS];
    t_word          dm_q;
    logic [MAW-1:0] dm_addr;
    logic           dm_we;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [DAW-1:0] idx_top, idx_m1, idx_m2;
    logic [7:0]     base;
    logic [31:0]    addr_sum;
    t_word          b;
    logic           load_out;

    assign idx_top  = r_dtop[DAW-1:0];
    assign idx_m1   = (r_dtop == '0) ? '0 : DAW'(r_dtop - DTW'(1));
    assign idx_m2   = (r_dtop < DTW'(2)) ? '0 : DAW'(r_dtop - DTW'(2));
    assign ds_raddr = (r_state == S_IDLE) ? idx_m1 : idx_m2;
    assign rs_raddr = (r_rtop == '0) ? '0 : RAW'(r_rtop - RTW'(1));
    // entry zero of the frame bases is fixed at zero and never written
    assign base     = (r_fidx == '0) ? 8'd0 : fb_q;
    assign addr_sum = r_in.arg_value + {24'd0, base};
    assign dm_addr  = addr_sum[MAW-1:0];
    assign b        = ds_q;

    always_ff @(posedge i_clk) begin
        ds_q <= ds_mem[ds_raddr];
        if (ds_we) begin
            ds_mem[ds_waddr] <= ds_wdata;
        end
        rs_q <= rs_mem[rs_raddr];
        if (rs_we) begin
            rs_mem[r_rtop[RAW-1:0]] <= r_ip;
        end
        fb_q <= fb_mem[r_fidx];
        if (fb_we) begin
            fb_mem[fb_waddr] <= fb_wdata;
        end
        dm_q <= dm_mem[dm_addr];
        if (dm_we) begin
            dm_mem[dm_addr] <= r_a;
        end
    end

    tsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_a      = r_a;
        n_ip     = r_ip;
        n_dtop   = r_dtop;
        n_rtop   = r_rtop;
        n_fidx   = r_fidx;
        n_res    = r_res;
        ds_we    = 1'b0;
        ds_waddr = idx_top;
        ds_wdata = r_a;
        rs_we    = 1'b0;
        fb_we    = 1'b0;
        fb_waddr = FAW'(r_fidx + FAW'(1));
        fb_wdata = base + r_in.arg_value[7:0];
        dm_we    = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = r_a.value;
        div_req.den   = b.value;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_word;
                    n_state = S_RD2;
                end
            end
            S_RD2: begin
                n_a     = ds_q;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_OUT;
                n_res.next_ip     = IP_W'(r_ip + IP_W'(1));
                n_res.print_valid = 1'b0;
                n_res.print_value = '0;
                n_res.print_tag   = '0;
                n_res.halted      = 1'b0;
                n_res.error_code  = ERR_NONE;
                case (r_in.func) inside
                    OP_PUSH, OP_ATR, OP_MOV, OP_ATK, OP_INF, OP_CLT, OP_DEP: begin
                        if (r_dtop >= DS_FULL) begin
                            n_res.error_code = ERR_STACK;
                        end else begin
                            ds_we    = 1'b1;
                            ds_wdata = '{tag: r_in.arg_tag, value: r_in.arg_value};
                            n_dtop   = r_dtop + DTW'(1);
                        end
                    end
                    OP_POP: begin
                        if (r_dtop == '0) begin
                            n_res.error_code = ERR_STACK;
                        end else begin
                            n_dtop = r_dtop - DTW'(1);
                        end
                    end
                    OP_DUP: begin
                        if (r_dtop == '0 || r_dtop >= DS_FULL) begin
                            n_res.error_code = ERR_STACK;
                        end else begin
                            ds_we  = 1'b1;
                            n_dtop = r_dtop + DTW'(1);
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (r_dtop < DTW'(2)) begin
                            n_res.error_code = ERR_STACK;
                        end else if (r_a.tag != TAG_NUM || b.tag != TAG_NUM) begin
                            n_res.error_code = ERR_TYPE;
                        end else if (r_in.func == OP_DIV) begin
                            if (b.value == '0) begin
                                n_res.error_code = ERR_DIV0;
                            end else begin
                                div_req.start = 1'b1;
                                n_state       = S_DIV;
                            end
                        end else begin
                            ds_we          = 1'b1;
                            ds_waddr       = idx_m2;
                            ds_wdata.tag   = TAG_NUM;
                            n_dtop         = r_dtop - DTW'(1);
                            if (r_in.func == OP_ADD) begin
                                ds_wdata.value = r_a.value + b.value;
                            end else if (r_in.func == OP_SUB) begin
                                ds_wdata.value = b.value - r_a.value;
                            end else begin
                                ds_wdata.value = r_a.value * b.value;
                            end
                        end
                    end
                    OP_JMP: begin
                        n_res.next_ip = r_in.arg_value[IP_W-1:0];
                    end
                    OP_JIT, OP_JIF: begin
                        if (r_dtop == '0) begin
                            n_res.error_code = ERR_STACK;
                        end else begin
                            n_dtop = r_dtop - DTW'(1);
                            if ((r_a.value != '0) == (r_in.func == OP_JIT)) begin
                                n_res.next_ip = r_in.arg_value[IP_W-1:0];
                            end
                        end
                    end
                    OP_CALL: begin
                        if (r_rtop >= RS_FULL) begin
                            n_res.error_code = ERR_STACK;
                        end else begin
                            rs_we         = 1'b1;
                            n_rtop        = r_rtop + RTW'(1);
                            n_res.next_ip = r_in.arg_value[IP_W-1:0];
                        end
                    end
                    OP_RET: begin
                        if (r_rtop == '0) begin
                            n_res.error_code = ERR_STACK;
                        end else begin
                            n_rtop        = r_rtop - RTW'(1);
                            n_res.next_ip = IP_W'(rs_q + IP_W'(1));
                        end
                    end
                    OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE, OP_NE: begin
                        if (r_dtop < DTW'(2)) begin
                            n_res.error_code = ERR_STACK;
                        end else begin
                            ds_we        = 1'b1;
                            ds_waddr     = idx_m2;
                            ds_wdata.tag = TAG_NUM;
                            n_dtop       = r_dtop - DTW'(1);
                            case (r_in.func)
                                OP_EQ: ds_wdata.value = {31'd0, b.value == r_a.value};
                                OP_GT: ds_wdata.value =
                                    {31'd0, $signed(r_a.value) < $signed(b.value)};
                                OP_GE: ds_wdata.value =
                                    {31'd0, !($signed(b.value) < $signed(r_a.value))};
                                OP_LT: ds_wdata.value =
                                    {31'd0, $signed(b.value) < $signed(r_a.value)};
                                OP_LE: ds_wdata.value =
                                    {31'd0, !($signed(r_a.value) < $signed(b.value))};
                                default: ds_wdata.value = {31'd0, b.value != r_a.value};
                            endcase
                        end
                    end
                    OP_STO: begin
                        if (r_dtop == '0) begin
                            n_res.error_code = ERR_STACK;
                        end else begin
                            dm_we  = 1'b1;
                            n_dtop = r_dtop - DTW'(1);
                        end
                    end
                    OP_RCL: begin
                        if (r_dtop >= DS_FULL) begin
                            n_res.error_code = ERR_STACK;
                        end else begin
                            ds_we    = 1'b1;
                            ds_wdata = dm_q;
                            n_dtop   = r_dtop + DTW'(1);
                        end
                    end
                    OP_END: begin
                        n_dtop        = '0;
                        n_res.halted  = 1'b1;
                        n_res.next_ip = r_ip;
                    end
                    OP_PRN: begin
                        if (r_dtop == '0) begin
                            n_res.error_code = ERR_STACK;
                        end else begin
                            n_res.print_valid = 1'b1;
                            n_res.print_value = r_a.value;
                            n_res.print_tag   = r_a.tag;
                        end
                    end
                    OP_ENTRY: begin
                        if (r_fidx >= FR_LAST) begin
                            n_res.error_code = ERR_FRAME;
                        end else begin
                            fb_we  = 1'b1;
                            n_fidx = r_fidx + FAW'(1);
                        end
                    end
                    OP_LEAVE: begin
                        if (r_fidx == '0) begin
                            n_res.error_code = ERR_FRAME;
                        end else begin
                            n_fidx = r_fidx - FAW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
                n_ip = n_res.next_ip;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    ds_we    = 1'b1;
                    ds_waddr = idx_m2;
                    ds_wdata = '{tag: TAG_NUM, value: div_rsp.quo};
                    n_dtop   = r_dtop - DTW'(1);
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign load_out = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ip        <= '0;
            r_dtop      <= '0;
            r_rtop      <= '0;
            r_fidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ip    <= n_ip;
            r_dtop  <= n_dtop;
            r_rtop  <= n_rtop;
            r_fidx  <= n_fidx;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_a   <= n_a;
        r_res <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_dtop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dtop <= DS_FULL)
        else $error("data stack pointer out of range");

    a_rtop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rtop <= RS_FULL && r_fidx <= FR_LAST)
        else $error("return or frame pointer out of range");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DIV)
        else $error("divider finished outside a divide");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result word loaded outside hand-off");

endmodule
`default_nettype wire

>>> rtl/tsm_div.sv
`default_nettype none
module tsm_div
    import tsm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic        r_neg;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic [31:0] n_rem;
    logic [31:0] n_quo;

    always_comb begin
        shifted = {r_rem, r_quo[31]};
        diff    = shifted - {1'b0, r_den};
        if (!diff[32]) begin
            n_rem = diff[31:0];
            n_quo = {r_quo[30:0], 1'b1};
        end else begin
            n_rem = shifted[31:0];
            n_quo = {r_quo[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // magnitudes in, sign fixed on the way out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num[31] ? (32'd0 - i_req.num) : i_req.num;
            r_den <= i_req.den[31] ? (32'd0 - i_req.den) : i_req.den;
            r_rem <= '0;
            r_neg <= i_req.num[31] ^ i_req.den[31];
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule
`default_nettype wire
